FILE: src/tgr_pkg.sv
// Shared types, constants and glyph tables of the text glyph rectangle generator.
package tgr_pkg;

  // Widths fixed by the register and field formats
  localparam int CFG_COORD_W  = 16;
  localparam int CFG_INDEX_W  = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int COLOR_W      = 16;
  localparam int SCALE_REG_W  = 8;
  localparam int CHAR_W       = 8;
  localparam int SIZE_W       = 4;

  // Font geometry
  localparam int GLYPH_ROWS   = 7;
  localparam int GLYPH_COLS   = 5;
  localparam int GLYPH_PIX    = GLYPH_ROWS * GLYPH_COLS;
  localparam int GLYPH_IDX_W  = 6;
  localparam int ROW_W        = 3;
  localparam int PIX_POS_W    = 6;

  // Layout constants
  localparam int CHAR_ADVANCE  = 7;
  localparam int LINE_DROP     = 9;
  localparam int ORIGIN_OFFSET = 2;

  // Reset values of the registers
  localparam logic [CFG_COORD_W-1:0] RST_START_X = 16'd0;
  localparam logic [CFG_COORD_W-1:0] RST_START_Y = 16'd0;
  localparam logic [COLOR_W-1:0]     RST_COLOR   = 16'hFFFF;
  localparam logic [SCALE_REG_W-1:0] RST_SCALE   = 8'd1;
  localparam logic [CFG_COORD_W-1:0] RST_WRAP    = 16'd316;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COLOR = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WRAP_LIMIT  = 3'd4;

  typedef struct packed {
    logic [CFG_COORD_W-1:0] start_x;
    logic [CFG_COORD_W-1:0] start_y;
    logic [COLOR_W-1:0]     pixel_color;
    logic [SCALE_REG_W-1:0] scale_setting;
    logic [CFG_COORD_W-1:0] wrap_limit;
  } cfg_t;

  typedef struct packed {
    logic                   known;
    logic [GLYPH_IDX_W-1:0] idx;
  } glyph_sel_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // Digits 0..9, letters 10..35, period 36
  function automatic glyph_sel_t glyph_lookup(input logic [CHAR_W-1:0] code);
    glyph_sel_t sel;
    sel.known = 1'b0;
    sel.idx   = '0;
    if (code >= 8'd48 && code <= 8'd57) begin
      sel.known = 1'b1;
      sel.idx   = GLYPH_IDX_W'(code - 8'd48);
    end else if (code >= 8'd65 && code <= 8'd90) begin
      sel.known = 1'b1;
      sel.idx   = GLYPH_IDX_W'(code - 8'd55);
    end else if (code == 8'd46) begin
      sel.known = 1'b1;
      sel.idx   = 6'd36;
    end
    return sel;
  endfunction

  // Bit row*5+col of the mask is the pixel at that row and column
  function automatic logic [GLYPH_PIX-1:0] pack_rows(
    input logic [7:0] r0, input logic [7:0] r1, input logic [7:0] r2,
    input logic [7:0] r3, input logic [7:0] r4, input logic [7:0] r5,
    input logic [7:0] r6);
    return {r6[4:0], r5[4:0], r4[4:0], r3[4:0], r2[4:0], r1[4:0], r0[4:0]};
  endfunction

  function automatic logic [GLYPH_PIX-1:0] glyph_mask(input logic [GLYPH_IDX_W-1:0] idx);
    logic [GLYPH_PIX-1:0] m;
    unique case (idx)
      6'd0:  m = pack_rows(8'h0E, 8'h11, 8'h13, 8'h15, 8'h19, 8'h11, 8'h0E);
      6'd1:  m = pack_rows(8'h1F, 8'h04, 8'h04, 8'h04, 8'h04, 8'h06, 8'h04);
      6'd2:  m = pack_rows(8'h1F, 8'h11, 8'h02, 8'h0C, 8'h10, 8'h11, 8'h0E);
      6'd3:  m = pack_rows(8'h0E, 8'h11, 8'h10, 8'h0C, 8'h10, 8'h11, 8'h0E);
      6'd4:  m = pack_rows(8'h10, 8'h10, 8'h1F, 8'h11, 8'h12, 8'h14, 8'h18);
      6'd5:  m = pack_rows(8'h0E, 8'h11, 8'h10, 8'h10, 8'h0F, 8'h01, 8'h1F);
      6'd6:  m = pack_rows(8'h0E, 8'h11, 8'h11, 8'h0F, 8'h01, 8'h02, 8'h0C);
      6'd7:  m = pack_rows(8'h04, 8'h04, 8'h04, 8'h08, 8'h10, 8'h11, 8'h1F);
      6'd8:  m = pack_rows(8'h0E, 8'h11, 8'h11, 8'h0E, 8'h11, 8'h11, 8'h0E);
      6'd9:  m = pack_rows(8'h06, 8'h08, 8'h10, 8'h1E, 8'h11, 8'h11, 8'h0E);
      6'd10: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h0E);
      6'd11: m = pack_rows(8'h0F, 8'h11, 8'h11, 8'h11, 8'h0F, 8'h11, 8'h0F);
      6'd12: m = pack_rows(8'h0E, 8'h11, 8'h01, 8'h01, 8'h01, 8'h11, 8'h0E);
      6'd13: m = pack_rows(8'h0F, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0F);
      6'd14: m = pack_rows(8'h1F, 8'h01, 8'h01, 8'h0F, 8'h01, 8'h01, 8'h1F);
      6'd15: m = pack_rows(8'h01, 8'h01, 8'h01, 8'h01, 8'h07, 8'h01, 8'h1F);
      6'd16: m = pack_rows(8'h0E, 8'h11, 8'h11, 8'h11, 8'h19, 8'h01, 8'h1E);
      6'd17: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11);
      6'd18: m = pack_rows(8'h0E, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0E);
      6'd19: m = pack_rows(8'h0E, 8'h11, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10);
      6'd20: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h09, 8'h07, 8'h09, 8'h11);
      6'd21: m = pack_rows(8'h1F, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
      6'd22: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h11, 8'h15, 8'h1B, 8'h11);
      6'd23: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h19, 8'h15, 8'h13, 8'h11);
      6'd24: m = pack_rows(8'h0E, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0E);
      6'd25: m = pack_rows(8'h01, 8'h01, 8'h01, 8'h01, 8'h0F, 8'h11, 8'h0F);
      6'd26: m = pack_rows(8'h16, 8'h09, 8'h11, 8'h11, 8'h11, 8'h11, 8'h0E);
      6'd27: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h11, 8'h0F, 8'h11, 8'h0F);
      6'd28: m = pack_rows(8'h0E, 8'h11, 8'h10, 8'h10, 8'h0E, 8'h01, 8'h1E);
      6'd29: m = pack_rows(8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h1F);
      6'd30: m = pack_rows(8'h0E, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11, 8'h11);
      6'd31: m = pack_rows(8'h04, 8'h0A, 8'h0A, 8'h11, 8'h11, 8'h11, 8'h11);
      6'd32: m = pack_rows(8'h11, 8'h1B, 8'h15, 8'h11, 8'h11, 8'h11, 8'h11);
      6'd33: m = pack_rows(8'h11, 8'h11, 8'h11, 8'h0A, 8'h04, 8'h0A, 8'h11);
      6'd34: m = pack_rows(8'h04, 8'h04, 8'h04, 8'h04, 8'h04, 8'h0A, 8'h11);
      6'd35: m = pack_rows(8'h1F, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h1F);
      6'd36: m = pack_rows(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: src/tgr_if.sv
// Handshake channel interfaces: character input, fill command output, register writes.
interface tgr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       new_string;

  modport source (output valid, output char_code, output new_string, input ready);
  modport sink   (input valid, input char_code, input new_string, output ready);
endinterface

interface tgr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic        [3:0]  rect_size;
  logic        [15:0] rect_color;
  logic               last_rect;

  modport source (output valid, output rect_x, output rect_y, output rect_size,
                  output rect_color, output last_rect, input ready);
  modport sink   (input valid, input rect_x, input rect_y, input rect_size,
                  input rect_color, input last_rect, output ready);
endinterface

interface tgr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/text_glyph_rect_generator_unit.sv
// A glyph's command passes the command queue, the back part's glyph registers and the
// output register. The pixel walker takes one glyph at a time, only when idle, and issues
// one square per cycle unless the output stalls. Blank and unknown codes are not queued.
// The front takes a character each cycle while the 2-entry command queue has room.
// Reset: registers to their defaults, cursor to zero, queue and output empty.
module text_glyph_rect_generator_unit #(
  parameter int COORD_BITS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgr_in_if.sink     in_i,
  tgr_out_if.source  out_o,
  tgr_cfg_if.sink    cfg_i
);
  import tgr_pkg::*;

  localparam int SW      = $clog2(MAX_SCALE + 1);
  localparam int ENTRY_W = GLYPH_IDX_W + 2*COORD_BITS + SW + COLOR_W;

  cfg_t               cfg_q;
  logic               push_valid, push_ready, pop_valid, pop_ready;
  logic [ENTRY_W-1:0] push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_x       <= RST_START_X;
      cfg_q.start_y       <= RST_START_Y;
      cfg_q.pixel_color   <= RST_COLOR;
      cfg_q.scale_setting <= RST_SCALE;
      cfg_q.wrap_limit    <= RST_WRAP;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_START_X:     cfg_q.start_x       <= cfg_i.data;
        REG_START_Y:     cfg_q.start_y       <= cfg_i.data;
        REG_PIXEL_COLOR: cfg_q.pixel_color   <= cfg_i.data;
        REG_SCALE:       cfg_q.scale_setting <= cfg_i.data[SCALE_REG_W-1:0];
        REG_WRAP_LIMIT:  cfg_q.wrap_limit    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tgr_front #(
    .COORD_BITS (COORD_BITS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .cfg_i        (cfg_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  tgr_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tgr_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_SCALE  (MAX_SCALE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

FILE: src/tgr_queue.sv
// Short command queue between the front and back parts.
module tgr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import tgr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: src/tgr_front.sv
// Front part: takes characters, keeps the cursor and queues glyph draw commands.
module tgr_front #(
  parameter int COORD_BITS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tgr_in_if.sink              in_i,
  input  tgr_pkg::cfg_t       cfg_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output logic [tgr_pkg::GLYPH_IDX_W + 2*COORD_BITS + $clog2(MAX_SCALE+1)
                + tgr_pkg::COLOR_W - 1:0] push_data_o
);
  import tgr_pkg::*;

  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int WIDE = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;

  logic [COORD_BITS-1:0] cursor_x_q, cursor_x_d, cursor_y_q, cursor_y_d;
  logic [COORD_BITS-1:0] start_x_c, start_y_c, cur_x, cur_y, two_s, adv_x;
  logic [COORD_BITS-1:0] base_x, base_y;
  logic signed [WIDE-1:0] sx_w, sy_w, adv_w, wrap_w;
  logic [SW-1:0]          scale;
  logic                   accept;
  glyph_sel_t             sel;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && push_ready_i;

  always_comb begin
    if (cfg_i.scale_setting >= 8'd1 && cfg_i.scale_setting <= SCALE_REG_W'(MAX_SCALE)) begin
      scale = cfg_i.scale_setting[SW-1:0];
    end else begin
      scale = SW'(1);
    end
  end

  // 16-bit registers sign-extended (or cut) to the coordinate width
  assign sx_w      = WIDE'(signed'(cfg_i.start_x));
  assign sy_w      = WIDE'(signed'(cfg_i.start_y));
  assign start_x_c = sx_w[COORD_BITS-1:0];
  assign start_y_c = sy_w[COORD_BITS-1:0];

  assign cur_x  = in_i.new_string ? start_x_c : cursor_x_q;
  assign cur_y  = in_i.new_string ? start_y_c : cursor_y_q;
  assign two_s  = COORD_BITS'(scale) * COORD_BITS'(ORIGIN_OFFSET);
  assign base_x = cur_x - two_s;
  assign base_y = cur_y - two_s;
  assign adv_x  = cur_x + COORD_BITS'(scale) * COORD_BITS'(CHAR_ADVANCE);
  assign adv_w  = WIDE'(signed'(adv_x));
  assign wrap_w = WIDE'(signed'(cfg_i.wrap_limit));

  always_comb begin
    cursor_x_d = cursor_x_q;
    cursor_y_d = cursor_y_q;
    if (accept) begin
      if (adv_w > wrap_w) begin
        cursor_x_d = start_x_c;
        cursor_y_d = cur_y - COORD_BITS'(LINE_DROP);
      end else begin
        cursor_x_d = adv_x;
        cursor_y_d = cur_y;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_x_q <= '0;
      cursor_y_q <= '0;
    end else begin
      cursor_x_q <= cursor_x_d;
      cursor_y_q <= cursor_y_d;
    end
  end

  // Blank and unknown codes only move the cursor
  assign sel          = glyph_lookup(in_i.char_code);
  assign push_valid_o = accept && sel.known;
  assign push_data_o  = {sel.idx, base_x, base_y, scale, cfg_i.pixel_color};

endmodule

FILE: src/tgr_back.sv
// Back part: walks a queued glyph's lit pixels; one fill command per cycle unless stalled.
module tgr_back #(
  parameter int COORD_BITS = 16,
  parameter int MAX_SCALE  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [tgr_pkg::GLYPH_IDX_W + 2*COORD_BITS + $clog2(MAX_SCALE+1)
                + tgr_pkg::COLOR_W - 1:0] pop_data_i,
  tgr_out_if.source     out_o
);
  import tgr_pkg::*;

  localparam int SW   = $clog2(MAX_SCALE + 1);
  localparam int PW   = SW + ROW_W;
  localparam int WIDE = (COORD_BITS > CFG_COORD_W) ? COORD_BITS : CFG_COORD_W;

  back_state_e state_q, state_d;

  logic [GLYPH_IDX_W-1:0] in_idx;
  logic [COORD_BITS-1:0]  in_bx, in_by;
  logic [SW-1:0]          in_scale;
  logic [COLOR_W-1:0]     in_color;

  logic [GLYPH_PIX-1:0]   mask_q, mask_clr;
  logic [COORD_BITS-1:0]  base_x_q, base_y_q, px, py;
  logic [SW-1:0]          scale_q;
  logic [COLOR_W-1:0]     color_q;

  logic [ROW_W-1:0]       row, col;
  logic [PIX_POS_W-1:0]   pos;
  logic [PW-1:0]          off_x, off_y;
  logic [WIDE-1:0]        px_w, py_w;
  logic [7:0]             scale8;
  logic                   slot_free, load, emit, last;

  logic                   out_valid_q;
  logic [15:0]            rect_x_q, rect_y_q;
  logic [SIZE_W-1:0]      rect_size_q;
  logic [COLOR_W-1:0]     rect_color_q;
  logic                   last_rect_q;

  assign {in_idx, in_bx, in_by, in_scale, in_color} = pop_data_i;

  // Lowest lit pixel left: row 0 first, columns ascending
  always_comb begin
    row = '0;
    col = '0;
    pos = '0;
    for (int r = GLYPH_ROWS - 1; r >= 0; r--) begin
      for (int c = GLYPH_COLS - 1; c >= 0; c--) begin
        if (mask_q[r*GLYPH_COLS + c]) begin
          row = ROW_W'(r);
          col = ROW_W'(c);
          pos = PIX_POS_W'(r*GLYPH_COLS + c);
        end
      end
    end
  end

  assign mask_clr  = mask_q & ~(GLYPH_PIX'(1) << pos);
  assign last      = (mask_clr == '0);
  assign slot_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (pop_valid_i) state_d = BK_EMIT;
      BK_EMIT: if (slot_free && last) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    pop_ready_o = (state_q == BK_IDLE);
    load        = pop_valid_i && (state_q == BK_IDLE);
    emit        = (state_q == BK_EMIT) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mask_q   <= glyph_mask(in_idx);
      base_x_q <= in_bx;
      base_y_q <= in_by;
      scale_q  <= in_scale;
      color_q  <= in_color;
    end else if (emit) begin
      mask_q   <= mask_clr;
    end
  end

  assign off_x  = PW'(col) * PW'(scale_q);
  assign off_y  = PW'(row) * PW'(scale_q);
  assign px     = base_x_q + COORD_BITS'(off_x);
  assign py     = base_y_q + COORD_BITS'(off_y);
  assign px_w   = WIDE'(px);
  assign py_w   = WIDE'(py);
  assign scale8 = 8'(scale_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      rect_x_q     <= px_w[15:0];
      rect_y_q     <= py_w[15:0];
      rect_size_q  <= scale8[SIZE_W-1:0];
      rect_color_q <= color_q;
      last_rect_q  <= last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.rect_x     = rect_x_q;
  assign out_o.rect_y     = rect_y_q;
  assign out_o.rect_size  = rect_size_q;
  assign out_o.rect_color = rect_color_q;
  assign out_o.last_rect  = last_rect_q;

endmodule

FILE: test/text_glyph_rect_generator_unit_tb.sv
// Self-checking testbench: glyph fill commands against a cycle-free font and cursor predictor.
`timescale 1ns / 100ps

module text_glyph_rect_generator_unit_tb;
  import tgr_pkg::*;

  localparam int TOP_SCALE     = 8;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 42;
  localparam int NUM_FONT      = 37;
  localparam int SLOT_PERIOD   = 36;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [3:0]  size;
    logic [15:0] color;
    logic        last;
  } rect_t;

  // One 5-bit row per entry, bit n is column n
  localparam logic [4:0] FONT_ROWS [NUM_FONT][7] = '{
    '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
    '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h06, 5'h04},
    '{5'h1F, 5'h11, 5'h02, 5'h0C, 5'h10, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h10, 5'h0C, 5'h10, 5'h11, 5'h0E},
    '{5'h10, 5'h10, 5'h1F, 5'h11, 5'h12, 5'h14, 5'h18},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h0F, 5'h01, 5'h1F},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
    '{5'h04, 5'h04, 5'h04, 5'h08, 5'h10, 5'h11, 5'h1F},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h0E},
    '{5'h0F, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h11, 5'h0F},
    '{5'h0E, 5'h11, 5'h01, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h0F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0F},
    '{5'h1F, 5'h01, 5'h01, 5'h0F, 5'h01, 5'h01, 5'h1F},
    '{5'h01, 5'h01, 5'h01, 5'h01, 5'h07, 5'h01, 5'h1F},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h19, 5'h01, 5'h1E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11},
    '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10},
    '{5'h11, 5'h11, 5'h11, 5'h09, 5'h07, 5'h09, 5'h11},
    '{5'h1F, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01, 5'h01},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h15, 5'h1B, 5'h11},
    '{5'h11, 5'h11, 5'h11, 5'h19, 5'h15, 5'h13, 5'h11},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h01, 5'h01, 5'h01, 5'h01, 5'h0F, 5'h11, 5'h0F},
    '{5'h16, 5'h09, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h11, 5'h11, 5'h11, 5'h11, 5'h0F, 5'h11, 5'h0F},
    '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h1E},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F},
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11},
    '{5'h04, 5'h0A, 5'h0A, 5'h11, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h1B, 5'h15, 5'h11, 5'h11, 5'h11, 5'h11},
    '{5'h11, 5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11},
    '{5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0A, 5'h11},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
    '{5'h04, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00}
  };

  class glyph_scoreboard;
    logic [15:0] org_x, org_y, color, wrap_x, pen_x, pen_y;
    logic [7:0]  scale;
    rect_t       rects_q[$];
    int          mismatches;

    function new();
      org_x      = RST_START_X;
      org_y      = RST_START_Y;
      color      = RST_COLOR;
      scale      = RST_SCALE;
      wrap_x     = RST_WRAP;
      pen_x      = '0;
      pen_y      = '0;
      mismatches = 0;
    endfunction

    function void write_reg(input logic [2:0] idx, input logic [15:0] val);
      case (idx)
        REG_START_X:     org_x  = val;
        REG_START_Y:     org_y  = val;
        REG_PIXEL_COLOR: color  = val;
        REG_SCALE:       scale  = val[7:0];
        REG_WRAP_LIMIT:  wrap_x = val;
        default: ;
      endcase
    endfunction

    function int font_slot(input logic [7:0] code);
      if (code >= "0" && code <= "9") return int'(code) - 48;
      if (code >= "A" && code <= "Z") return int'(code) - 55;
      if (code == ".") return SLOT_PERIOD;
      return -1;
    endfunction

    // Queue the squares of one character, then move the cursor on
    function void note_char(input logic [7:0] code, input logic fresh);
      logic [15:0] s, bx, by;
      rect_t       r;
      int          slot, drawn;
      s = (scale >= 8'd1 && scale <= 8'(TOP_SCALE)) ? {8'd0, scale} : 16'd1;
      if (fresh) begin
        pen_x = org_x;
        pen_y = org_y;
      end
      slot  = font_slot(code);
      drawn = 0;
      if (slot >= 0) begin
        bx = pen_x - 16'(ORIGIN_OFFSET) * s;
        by = pen_y - 16'(ORIGIN_OFFSET) * s;
        for (int row = 0; row < GLYPH_ROWS; row++) begin
          for (int col = 0; col < GLYPH_COLS; col++) begin
            if (FONT_ROWS[slot][row][col]) begin
              r.x     = bx + 16'(col) * s;
              r.y     = by + 16'(row) * s;
              r.size  = s[3:0];
              r.color = color;
              r.last  = 1'b0;
              rects_q.push_back(r);
              drawn++;
            end
          end
        end
        if (drawn > 0) rects_q[rects_q.size()-1].last = 1'b1;
      end
      pen_x = pen_x + 16'(CHAR_ADVANCE) * s;
      if ($signed(pen_x) > $signed(wrap_x)) begin
        pen_x = org_x;
        pen_y = pen_y - 16'(LINE_DROP);
      end
    endfunction

    function void check_rect(input rect_t got);
      rect_t want;
      if (rects_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected fill command x=%0d y=%0d size=%0d color=%h last=%b",
                   $signed(got.x), $signed(got.y), got.size, got.color, got.last);
        return;
      end
      want = rects_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.size !== want.size ||
          got.color !== want.color || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("fill command mismatch: expected x=%0d y=%0d size=%0d color=%h last=%b,%s",
                   $signed(want.x), $signed(want.y), want.size, want.color, want.last,
                   $sformatf(" got x=%0d y=%0d size=%0d color=%h last=%b",
                   $signed(got.x), $signed(got.y), got.size, got.color, got.last));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic long_hold_go;
  int   burst_left;
  int   cycle_count;

  glyph_scoreboard sb = new();

  tgr_in_if  char_ch ();
  tgr_out_if rect_ch ();
  tgr_cfg_if cfg_ch ();

  text_glyph_rect_generator_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (rect_ch),
    .cfg_i  (cfg_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Offer one character and hold it until taken; bursts end in a random gap
  task automatic offer_char(input logic [7:0] code, input logic fresh);
    char_ch.valid      <= 1'b1;
    char_ch.char_code  <= code;
    char_ch.new_string <= fresh;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
    sb.note_char(code, fresh);
    burst_left--;
    if (burst_left <= 0) begin
      char_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
  endtask

  // Stop offering and let every queued square come out before touching registers
  task automatic drain();
    char_ch.valid <= 1'b0;
    while (sb.rects_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [15:0] sx, input logic [15:0] sy,
                          input logic [15:0] col, input logic [7:0] sc,
                          input logic [15:0] wl);
    logic [2:0]  idx [5];
    logic [15:0] val [5];
    idx = '{REG_START_X, REG_START_Y, REG_PIXEL_COLOR, REG_SCALE, REG_WRAP_LIMIT};
    val = '{sx, sy, col, {8'd0, sc}, wl};
    for (int k = 0; k < 5; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx[k];
      cfg_ch.data  <= val[k];
      @(posedge clk_i);
      while (!cfg_ch.ready) @(posedge clk_i);
      sb.write_reg(idx[k], val[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Receiver: checks squares and stalls on a changing duty pattern
  initial begin
    rect_t got;
    int    mode_left, stall_pct, hold_left;
    bit    hold_taken;
    rect_ch.ready <= 1'b0;
    mode_left  = 0;
    stall_pct  = 0;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rect_ch.valid && rect_ch.ready) begin
        got.x     = rect_ch.rect_x;
        got.y     = rect_ch.rect_y;
        got.size  = rect_ch.rect_size;
        got.color = rect_ch.rect_color;
        got.last  = rect_ch.last_rect;
        sb.check_rect(got);
      end
      if (long_hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = LONG_HOLD;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rect_ch.ready <= 1'b0;
      end else begin
        rect_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("text_glyph_rect_generator_unit verification failed");
    $finish;
  end

  initial begin
    logic [7:0]  code;
    logic [15:0] sx, sy, col, wl;
    logic [7:0]  sc;
    rst_ni              = 1'b0;
    long_hold_go       <= 1'b0;
    char_ch.valid      <= 1'b0;
    char_ch.char_code  <= '0;
    char_ch.new_string <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= '0;
    cfg_ch.data        <= '0;
    burst_left          = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: range ends of the known codes and their unknown neighbours
    offer_char("A", 1'b1);
    offer_char("0", 1'b0);
    offer_char("9", 1'b0);
    offer_char("Z", 1'b0);
    offer_char(".", 1'b0);
    offer_char(" ", 1'b0);
    offer_char(8'h00, 1'b0);
    offer_char(8'hFF, 1'b1);
    offer_char("/", 1'b0);
    offer_char(":", 1'b0);
    offer_char("@", 1'b0);
    offer_char("[", 1'b0);
    offer_char(",", 1'b0);
    offer_char("a", 1'b0);
    drain();

    // Largest scale at the coordinate extremes, wrapping on every character
    set_regs(16'h7FFF, 16'h8000, 16'h0000, 8'd8, 16'h8000);
    offer_char("W", 1'b1);
    offer_char("B", 1'b0);
    offer_char(".", 1'b0);
    offer_char(" ", 1'b0);
    offer_char("8", 1'b0);
    drain();

    // Zero scale acts as one; wrap never taken
    set_regs(16'h8000, 16'h7FFF, 16'hA5A5, 8'd0, 16'h7FFF);
    offer_char("X", 1'b1);
    offer_char("1", 1'b0);
    offer_char(" ", 1'b0);
    drain();
    set_regs(16'd5, 16'd100, 16'h5A5A, 8'd9, 16'd40);
    offer_char("4", 1'b1);
    drain();
    set_regs(16'd5, 16'd100, 16'h1234, 8'd255, 16'd40);
    offer_char("Q", 1'b0);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       sx = 16'h8000;
        1:       sx = 16'h7FFF;
        2:       sx = 16'd0;
        default: sx = 16'($urandom_range(0, 16'hFFFF));
      endcase
      sy  = ($urandom_range(0, 3) == 0) ? 16'h8000 : 16'($urandom_range(0, 16'hFFFF));
      col = 16'($urandom_range(0, 16'hFFFF));
      case ($urandom_range(0, 7))
        0:       sc = 8'd0;
        1:       sc = 8'd9;
        2:       sc = 8'($urandom_range(0, 255));
        default: sc = 8'($urandom_range(1, TOP_SCALE));
      endcase
      case ($urandom_range(0, 4))
        0:       wl = 16'h7FFF;
        1:       wl = 16'h8000;
        default: wl = sx + 16'($urandom_range(20, 300));
      endcase
      set_regs(sx, sy, col, sc, wl);
      // Receiver holds off while characters keep coming, so the input backs up
      if (p == 1) long_hold_go <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 24))
          0, 1:    code = " ";
          2, 3, 4: code = 8'($urandom_range(0, 255));
          5, 6:    code = ".";
          7, 8, 9, 10, 11, 12: code = 8'("0" + $urandom_range(0, 9));
          default: code = 8'("A" + $urandom_range(0, 25));
        endcase
        offer_char(code, (n == 0) || ($urandom_range(0, 11) == 0));
      end
      drain();
    end

    if (sb.mismatches == 0 && sb.rects_q.size() == 0) begin
      $display("text_glyph_rect_generator_unit verification clean");
    end else begin
      $display("text_glyph_rect_generator_unit verification failed");
    end
    $finish;
  end

endmodule
